// ===== sv/two_bit_bitmap_extent_allocator_macros.svh =====
// Assertion macros for the two-bit bitmap extent allocator.
`ifndef TWO_BIT_BITMAP_EXTENT_ALLOCATOR_MACROS_SVH
`define TWO_BIT_BITMAP_EXTENT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define TBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TBA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/tbba_pkg.sv =====
package tbba_pkg;
    localparam int MaxBlocks     = 65536;
    localparam int StatesPerWord = 16;
    localparam int WordCount     = MaxBlocks / StatesPerWord;
    localparam int BlkW          = $clog2(MaxBlocks);
    localparam int SlotW         = $clog2(StatesPerWord);
    localparam int WordAddrW     = BlkW - SlotW;
    localparam int WordW         = 2 * StatesPerWord;
    localparam int CntW          = BlkW + 1;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FIND  = 2'd2;
    localparam logic [1:0] KIND_ALLOC = 2'd3;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_USED = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NONE  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    localparam logic CFG_DATA_BLOCKS = 1'b0;
    localparam logic CFG_FREE_BLOCKS = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WORK,
        S_OUT
    } fsm_t;
endpackage

// ===== sv/two_bit_bitmap_extent_allocator.sv =====
// Sequence: set and read pass through S_READ and S_WORK to the output register;
//   find and allocate repeat both per block walked; an out-of-range index or
//   early reject goes straight to the output register.
// Throughput: one item at a time; the next is accepted once the result is taken.
// Reset: rst_n is asynchronous, active low; a clearing pass then zeroes all
//   4096 words of the state memory, one word a cycle, before the first item.
`include "two_bit_bitmap_extent_allocator_macros.svh"
module two_bit_bitmap_extent_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[1:0], block_index[17:2], block_state[19:18], extent_length[36:20]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], result_block[17:2], result_length[34:18], read_state[36:35]
    output logic [39:0] m_tdata
);
    import tbba_pkg::*;

    logic [WordW-1:0] mem [WordCount];
    logic [WordW-1:0] rdata_reg;
    logic [WordAddrW-1:0] raddr;
    logic             we;
    logic [WordAddrW-1:0] waddr;
    logic [WordW-1:0] wdata;

    fsm_t state_reg, state_next;
    logic [16:0] data_blocks_reg, free_blocks_reg;
    logic [WordAddrW-1:0] clr_reg, clr_next;
    logic [1:0]  kind_reg, kind_next, st_reg, st_next;
    logic [BlkW-1:0] start_reg, start_next;
    logic [CntW-1:0] len_reg, len_next;
    logic [CntW-1:0] pos_reg, pos_next;
    logic [CntW-1:0] run_reg, run_next;
    logic [CntW-1:0] runst_reg, runst_next;
    logic        first_reg, first_next;
    logic [1:0]  ostat_reg, ostat_next, orst_reg, orst_next;
    logic [BlkW-1:0] oblk_reg, oblk_next;
    logic [CntW-1:0] olen_reg, olen_next;

    logic [CntW-1:0] n;
    logic [1:0]  cur;
    logic [WordW-1:0] modw;
    logic [BlkW-1:0] pos_b;

    assign n = (data_blocks_reg > 17'(MaxBlocks)) ? CntW'(MaxBlocks) : data_blocks_reg;
    assign pos_b = pos_reg[BlkW-1:0];
    assign cur = rdata_reg[2*pos_b[SlotW-1:0] +: 2];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            data_blocks_reg <= 17'(MaxBlocks);
            free_blocks_reg <= 17'(MaxBlocks);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we && cfg_index == CFG_DATA_BLOCKS)
            begin
                data_blocks_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_FREE_BLOCKS)
            begin
                free_blocks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        st_reg    <= st_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        pos_reg   <= pos_next;
        run_reg   <= run_next;
        runst_reg <= runst_next;
        first_reg <= first_next;
        ostat_reg <= ostat_next;
        orst_reg  <= orst_next;
        oblk_reg  <= oblk_next;
        olen_reg  <= olen_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        kind_next  = kind_reg;
        st_next    = st_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        run_next   = run_reg;
        runst_next = runst_reg;
        first_next = first_reg;
        ostat_next = ostat_reg;
        orst_next  = orst_reg;
        oblk_next  = oblk_reg;
        olen_next  = olen_reg;
        raddr      = pos_b[BlkW-1:SlotW];
        we         = 1'b0;
        waddr      = pos_b[BlkW-1:SlotW];
        modw       = rdata_reg;
        wdata      = modw;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == WordAddrW'(WordCount - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tdata[1:0];
                    start_next = s_tdata[17:2];
                    st_next    = s_tdata[19:18];
                    len_next   = s_tdata[36:20];
                    pos_next   = {1'b0, s_tdata[17:2]};
                    first_next = 1'b1;
                    run_next   = '0;
                    ostat_next = STATUS_OK;
                    oblk_next  = '0;
                    olen_next  = '0;
                    orst_next  = '0;
                    if ({1'b0, s_tdata[17:2]} >= n)
                    begin
                        ostat_next = STATUS_RANGE;
                        state_next = S_OUT;
                    end
                    else if (s_tdata[1:0] == KIND_FIND && s_tdata[19:18] == ST_FREE
                             && {1'b0, free_blocks_reg} < s_tdata[36:20])
                    begin
                        ostat_next = STATUS_NONE;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_WORK;
            end
            S_WORK:
            begin
                modw = rdata_reg;
                state_next = S_READ;
                case (kind_reg)
                    KIND_SET:
                    begin
                        modw[2*pos_b[SlotW-1:0] +: 2] = st_reg;
                        we = 1'b1;
                        oblk_next = start_reg;
                        state_next = S_OUT;
                    end
                    KIND_READ:
                    begin
                        oblk_next = start_reg;
                        orst_next = cur;
                        state_next = S_OUT;
                    end
                    KIND_FIND:
                    begin
                        pos_next = pos_reg + 1'b1;
                        if (st_reg != ST_FREE || len_reg == '0)
                        begin
                            if (cur == st_reg)
                            begin
                                oblk_next = pos_b;
                                olen_next = CntW'(1);
                                state_next = S_OUT;
                            end
                        end
                        else if (cur == ST_FREE)
                        begin
                            if (run_reg == '0)
                            begin
                                runst_next = pos_reg;
                            end
                            run_next = run_reg + 1'b1;
                            if (run_reg + 1'b1 >= len_reg)
                            begin
                                oblk_next = (run_reg == '0) ? pos_b : runst_reg[BlkW-1:0];
                                olen_next = run_reg + 1'b1;
                                state_next = S_OUT;
                            end
                        end
                        else
                        begin
                            run_next = '0;
                        end
                        if (state_next != S_OUT && pos_reg + 1'b1 >= n)
                        begin
                            ostat_next = STATUS_NONE;
                            oblk_next  = '0;
                            olen_next  = '0;
                            state_next = S_OUT;
                        end
                    end
                    default:
                    begin
                        oblk_next = start_reg;
                        if (first_reg)
                        begin
                            modw[2*pos_b[SlotW-1:0] +: 2] = st_reg;
                            we = 1'b1;
                            first_next = 1'b0;
                            run_next = CntW'(1);
                            pos_next = pos_reg + 1'b1;
                            if (len_reg <= CntW'(1) || pos_reg + 1'b1 >= n)
                            begin
                                olen_next = CntW'(1);
                                state_next = S_OUT;
                            end
                        end
                        else if (cur != ST_FREE)
                        begin
                            olen_next = run_reg;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            modw[2*pos_b[SlotW-1:0] +: 2] = ST_USED;
                            we = 1'b1;
                            run_next = run_reg + 1'b1;
                            pos_next = pos_reg + 1'b1;
                            if (run_reg + 1'b1 >= len_reg || pos_reg + 1'b1 >= n)
                            begin
                                olen_next = run_reg + 1'b1;
                                state_next = S_OUT;
                            end
                        end
                    end
                endcase
                wdata = modw;
                if (state_next == S_READ)
                begin
                    raddr = pos_next[BlkW-1:SlotW];
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_IDLE)
        begin
            raddr = s_tdata[17:2+SlotW];
        end
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {3'b0, orst_reg, olen_reg, oblk_reg, ostat_reg};

    `TBA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !s_tready)
    `TBA_ASSERT_IMPL(a_range_zero, clk, rst_n,
        m_tvalid && ostat_reg == STATUS_RANGE, olen_reg == '0 && oblk_reg == '0)
    `TBA_ASSERT_NEXT(a_hold_out, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
endmodule
